>>> rtl/lru_block_buffer_cache_top_macros.svh
// assertion macros for the buffer cache checker
`ifndef LRU_BLOCK_BUFFER_CACHE_TOP_MACROS_SVH
`define LRU_BLOCK_BUFFER_CACHE_TOP_MACROS_SVH
// assert that an antecedent implies a consequent in the next cycle
`define LBC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
// assert that an antecedent implies a consequent in the same cycle
`define LBC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/lbc_pkg.sv
// shared types and codes for the buffer cache controller
package lbc_pkg;
    localparam logic [1:0] OP_READ    = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_PIN     = 2'd2;
    localparam logic [1:0] OP_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFREE  = 2'd1;
    localparam logic [1:0] ST_UNDER   = 2'd2;
    localparam logic [1:0] ST_OVER    = 2'd3;

    localparam int DEV_W = 8;
    localparam int BLK_W = 32;
    localparam int CNT_W = 8;
    localparam int OUT_SLOT_W = 5;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic search;
        logic commit;
    } lbc_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic done;
    } lbc_stat_t;
endpackage

>>> rtl/lbc_ctrl.sv
// controller state machine: load, search, commit, deliver
module lbc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output lbc_pkg::lbc_cmd_t cmd,
    input  lbc_pkg::lbc_stat_t stat
);
    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT, S_OUT} state_t;
    state_t state_reg;
    logic   out_valid_reg;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign cmd.load   = in_valid && in_ready;
    assign cmd.search = (state_reg == S_SEARCH);
    assign cmd.commit = (state_reg == S_COMMIT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (in_valid) state_reg <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (stat.done) state_reg <= S_COMMIT;
                end
                S_COMMIT: begin
                    state_reg     <= S_OUT;
                    out_valid_reg <= 1'b1;
                end
                S_OUT: begin
                    if (out_ready) begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

>>> rtl/lbc_datapath.sv
// slot tag, count and rank arrays with the lookup and update logic
module lbc_datapath #(
    parameter int SLOTS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lbc_pkg::lbc_cmd_t                   cmd,
    output lbc_pkg::lbc_stat_t                  stat,
    input  logic [1:0]                          in_op,
    input  logic [lbc_pkg::DEV_W-1:0]           in_dev,
    input  logic [lbc_pkg::BLK_W-1:0]           in_blk,
    input  logic [lbc_pkg::OUT_SLOT_W-1:0]      in_slot,
    output logic [lbc_pkg::OUT_SLOT_W-1:0]      res_slot,
    output logic                                res_hit,
    output logic                                res_need,
    output logic [1:0]                          res_status
);
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = lbc_pkg::CNT_W;
    localparam logic [CW-1:0] CMAX = {CW{1'b1}};

    logic [lbc_pkg::DEV_W-1:0] dtag_reg [SLOTS];
    logic [lbc_pkg::BLK_W-1:0] btag_reg [SLOTS];
    logic [SLOTS-1:0]          valid_reg;
    logic [CW-1:0]             cnt_reg  [SLOTS];
    logic [IW-1:0]             rank_reg [SLOTS];

    logic [1:0]                op_reg;
    logic [lbc_pkg::DEV_W-1:0] dev_reg;
    logic [lbc_pkg::BLK_W-1:0] blk_reg;
    logic [lbc_pkg::OUT_SLOT_W-1:0] slot_reg;

    // sequential scan over slots: one slot per cycle
    logic [IW-1:0] idx_reg;
    logic          hfound_reg, ffound_reg;
    logic [IW-1:0] hbest_reg, fbest_reg;
    logic [IW-1:0] hrank_reg, frank_reg;
    logic          last;
    logic          match, free;

    assign last  = (idx_reg == IW'(SLOTS - 1));
    assign match = (dtag_reg[idx_reg] == dev_reg) && (btag_reg[idx_reg] == blk_reg);
    assign free  = (cnt_reg[idx_reg] == '0);
    assign stat.done = cmd.search && last;

    logic in_range;
    logic [IW-1:0] sidx;
    assign in_range = (32'(slot_reg) < 32'(SLOTS));
    assign sidx = IW'(slot_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg   <= in_op;
            dev_reg  <= in_dev;
            blk_reg  <= in_blk;
            slot_reg <= in_slot;
            idx_reg  <= '0;
            hfound_reg <= 1'b0;
            ffound_reg <= 1'b0;
            hbest_reg  <= '0;
            fbest_reg  <= '0;
            hrank_reg  <= '0;
            frank_reg  <= '0;
        end else if (cmd.search) begin
            if (!last) idx_reg <= idx_reg + 1'b1;
            if (match && (!hfound_reg || rank_reg[idx_reg] < hrank_reg)) begin
                hfound_reg <= 1'b1;
                hbest_reg  <= idx_reg;
                hrank_reg  <= rank_reg[idx_reg];
            end
            if (free && (!ffound_reg || rank_reg[idx_reg] > frank_reg)) begin
                ffound_reg <= 1'b1;
                fbest_reg  <= idx_reg;
                frank_reg  <= rank_reg[idx_reg];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                dtag_reg[i] <= '0;
                btag_reg[i] <= '0;
                cnt_reg[i]  <= '0;
                rank_reg[i] <= IW'(SLOTS - 1 - i);
            end
        end else if (cmd.commit) begin
            res_hit    <= 1'b0;
            res_need   <= 1'b0;
            res_status <= lbc_pkg::ST_OK;
            res_slot   <= slot_reg;
            if (op_reg == lbc_pkg::OP_READ) begin
                if (hfound_reg) begin
                    res_slot <= lbc_pkg::OUT_SLOT_W'(hbest_reg);
                    res_hit  <= 1'b1;
                    if (cnt_reg[hbest_reg] == CMAX) begin
                        res_status <= lbc_pkg::ST_OVER;
                    end else begin
                        cnt_reg[hbest_reg]   <= cnt_reg[hbest_reg] + 1'b1;
                        res_need             <= !valid_reg[hbest_reg];
                        valid_reg[hbest_reg] <= 1'b1;
                    end
                end else if (ffound_reg) begin
                    res_slot <= lbc_pkg::OUT_SLOT_W'(fbest_reg);
                    res_need <= 1'b1;
                    dtag_reg[fbest_reg]  <= dev_reg;
                    btag_reg[fbest_reg]  <= blk_reg;
                    cnt_reg[fbest_reg]   <= CW'(1);
                    valid_reg[fbest_reg] <= 1'b1;
                end else begin
                    res_slot   <= '0;
                    res_status <= lbc_pkg::ST_NOFREE;
                end
            end else if (in_range) begin
                if (op_reg == lbc_pkg::OP_PIN) begin
                    if (cnt_reg[sidx] == CMAX) res_status <= lbc_pkg::ST_OVER;
                    else cnt_reg[sidx] <= cnt_reg[sidx] + 1'b1;
                end else if (cnt_reg[sidx] == '0) begin
                    res_status <= lbc_pkg::ST_UNDER;
                end else begin
                    cnt_reg[sidx] <= cnt_reg[sidx] - 1'b1;
                    // last release moves the slot to the front
                    if (op_reg == lbc_pkg::OP_RELEASE && cnt_reg[sidx] == CW'(1)) begin
                        for (int i = 0; i < SLOTS; i++) begin
                            if (rank_reg[i] < rank_reg[sidx]) rank_reg[i] <= rank_reg[i] + 1'b1;
                        end
                        rank_reg[sidx] <= '0;
                    end
                end
            end
        end
    end
endmodule

>>> rtl/lru_block_buffer_cache_top.sv
// flow: an accepted item is searched across all slots, then committed, then its result
// is held valid until taken; the tag search visits one slot per cycle, and no new item
// is accepted until the previous result has been taken
// reset: synchronous active-low aresetn clears tags, counts, valid marks,
// restores the initial recency order and clears the result valid flag
module lru_block_buffer_cache_top #(
    parameter int SLOTS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // operation[1:0], dev[9:2], block_number[41:10], slot[46:42]
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_slot[4:0], hit[5], need_read[6], status[8:7]
    output logic [15:0] m_tdata
);
    lbc_pkg::lbc_cmd_t  cmd;
    lbc_pkg::lbc_stat_t stat;
    logic [4:0] res_slot;
    logic       res_hit, res_need;
    logic [1:0] res_status;

    lbc_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .cmd(cmd), .stat(stat)
    );

    lbc_datapath #(.SLOTS(SLOTS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_op(s_tdata[1:0]), .in_dev(s_tdata[9:2]),
        .in_blk(s_tdata[41:10]), .in_slot(s_tdata[46:42]),
        .res_slot(res_slot), .res_hit(res_hit), .res_need(res_need),
        .res_status(res_status)
    );

    assign m_tdata = {7'b0, res_status, res_need, res_hit, res_slot};
endmodule

>>> rtl/lbc_checker.sv
// port-level checker for the buffer cache, bound to the top level
`include "lru_block_buffer_cache_top_macros.svh"
module lbc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);
    `LBC_ASSERT_NOW(a_no_overlap, aclk, aresetn, m_tvalid, !s_tready)
    `LBC_ASSERT_NEXT(a_accept_busy, aclk, aresetn, s_tvalid && s_tready, !s_tready && !m_tvalid)
    `LBC_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `LBC_ASSERT_NOW(a_flags, aclk, aresetn, m_tvalid && m_tdata[6], m_tdata[8:7] == lbc_pkg::ST_OK)
endmodule

bind lru_block_buffer_cache_top lbc_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);

>>> bench/lru_block_buffer_cache_top_test.sv
// testbench for the buffer cache controller: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module lru_block_buffer_cache_top_test;
    localparam int NSLOT = 32;

    // lowest field last, matching the result packing
    typedef struct packed {
        logic [1:0] status;
        logic       need_read;
        logic       hit;
        logic [4:0] rslot;
    } cache_reply_t;

    class cache_scoreboard;
        logic [7:0]  dev_tag [NSLOT];
        logic [31:0] blk_tag [NSLOT];
        logic        valid_mark [NSLOT];
        logic [7:0]  ref_cnt [NSLOT];
        int unsigned rank [NSLOT];
        cache_reply_t pending[$];
        int errors;

        function new();
            errors = 0;
            for (int i = 0; i < NSLOT; i++) begin
                dev_tag[i] = 0;
                blk_tag[i] = 0;
                valid_mark[i] = 0;
                ref_cnt[i] = 0;
                rank[i] = NSLOT - 1 - i;
            end
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] dev, logic [31:0] blk,
                                   logic [4:0] sl);
            cache_reply_t r;
            bit found;
            int best;
            int unsigned rk;
            r = '0;
            found = 0;
            best = 0;
            if (op == lbc_pkg::OP_READ) begin
                for (int i = 0; i < NSLOT; i++)
                    if (dev_tag[i] == dev && blk_tag[i] == blk &&
                        (!found || rank[i] < rank[best])) begin
                        found = 1;
                        best = i;
                    end
                if (found) begin
                    r.rslot = 5'(best);
                    r.hit = 1;
                    if (ref_cnt[best] == 8'hff) begin
                        r.status = lbc_pkg::ST_OVER;
                    end else begin
                        ref_cnt[best]++;
                        r.need_read = !valid_mark[best];
                        valid_mark[best] = 1;
                        r.status = lbc_pkg::ST_OK;
                    end
                end else begin
                    for (int i = 0; i < NSLOT; i++)
                        if (ref_cnt[i] == 0 && (!found || rank[i] > rank[best])) begin
                            found = 1;
                            best = i;
                        end
                    if (!found) begin
                        r.status = lbc_pkg::ST_NOFREE;
                    end else begin
                        dev_tag[best] = dev;
                        blk_tag[best] = blk;
                        ref_cnt[best] = 1;
                        valid_mark[best] = 1;
                        r.rslot = 5'(best);
                        r.need_read = 1;
                        r.status = lbc_pkg::ST_OK;
                    end
                end
            end else begin
                r.rslot = sl;
                if (op == lbc_pkg::OP_PIN) begin
                    if (ref_cnt[sl] == 8'hff) r.status = lbc_pkg::ST_OVER;
                    else begin
                        ref_cnt[sl]++;
                        r.status = lbc_pkg::ST_OK;
                    end
                end else if (ref_cnt[sl] == 0) begin
                    r.status = lbc_pkg::ST_UNDER;
                end else begin
                    ref_cnt[sl]--;
                    r.status = lbc_pkg::ST_OK;
                    // freed by release: move to the front of the recency order
                    if (op == lbc_pkg::OP_RELEASE && ref_cnt[sl] == 0) begin
                        rk = rank[sl];
                        for (int i = 0; i < NSLOT; i++)
                            if (rank[i] < rk) rank[i]++;
                        rank[sl] = 0;
                    end
                end
            end
            pending.push_back(r);
        endfunction

        function void check_reply(cache_reply_t got);
            cache_reply_t want;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected reply %h", got);
                return;
            end
            want = pending.pop_front();
            if (got.rslot != want.rslot || got.hit != want.hit ||
                got.need_read != want.need_read || got.status != want.status) begin
                errors++;
                if (errors <= 10)
                    $display("reply mismatch: expected slot %0d hit %0d need %0d st %0d,",
                             want.rslot, want.hit, want.need_read, want.status,
                             " got slot %0d hit %0d need %0d st %0d",
                             got.rslot, got.hit, got.need_read, got.status);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    cache_scoreboard board;
    bit quiet_tail;
    bit sending_done;

    lru_block_buffer_cache_top #(.SLOTS(NSLOT)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    initial begin
        aclk = 0;
        forever #1 aclk = ~aclk;
    end

    // small working set of tags so hits, refills and exhaustion all happen
    logic [7:0]  dev_pool [8];
    logic [31:0] blk_pool [8];

    task automatic send_request(logic [1:0] op, logic [7:0] dev, logic [31:0] blk,
                                logic [4:0] sl);
        int gap;
        if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {1'b0, sl, blk, dev, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_request(op, dev, blk, sl);
        @(negedge aclk);
    endtask

    task automatic random_request();
        logic [1:0] op;
        int k;
        op = 2'($urandom_range(0, 3));
        k = $urandom_range(0, 9);
        if (op == lbc_pkg::OP_READ && k < 8)
            send_request(op, dev_pool[k], blk_pool[k], 5'($urandom));
        else
            send_request(op, 8'($urandom), $urandom, 5'($urandom));
    endtask

    initial begin
        board = new();
        quiet_tail = 0;
        sending_done = 0;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        for (int i = 0; i < 8; i++) begin
            dev_pool[i] = (i == 0) ? 8'h00 : 8'($urandom);
            blk_pool[i] = (i == 0) ? 32'h0 : $urandom;
        end
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
        // directed: reset tag match, underflow, pin, extremes
        send_request(lbc_pkg::OP_READ, 8'h00, 32'h0, 5'd0);
        send_request(lbc_pkg::OP_READ, 8'h00, 32'h0, 5'd31);
        send_request(lbc_pkg::OP_RELEASE, 8'hff, 32'hffffffff, 5'd5);
        send_request(lbc_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd31);
        send_request(lbc_pkg::OP_PIN, 8'h00, 32'h0, 5'd31);
        send_request(lbc_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd31);
        send_request(lbc_pkg::OP_READ, 8'hff, 32'hffffffff, 5'd0);
        send_request(lbc_pkg::OP_READ, 8'hff, 32'hffffffff, 5'd0);
        send_request(lbc_pkg::OP_READ, 8'h5a, 32'h80000001, 5'd0);
        send_request(lbc_pkg::OP_RELEASE, 8'h00, 32'h0, 5'd31);
        // pin slot 3 to the top and past it
        for (int i = 0; i < 256; i++) send_request(lbc_pkg::OP_PIN, 8'h00, 32'h0, 5'd3);
        for (int i = 0; i < 256; i++) send_request(lbc_pkg::OP_UNPIN, 8'h00, 32'h0, 5'd3);
        // read NSLOT + 1 new tags, more than the slots left free, so the last ones find none
        for (int i = 0; i < NSLOT + 1; i++)
            send_request(lbc_pkg::OP_READ, 8'h10, 32'(i), 5'd0);
        for (int i = 0; i < NSLOT; i++)
            send_request(lbc_pkg::OP_RELEASE, 8'h00, 32'h0, 5'(i));
        for (int i = 0; i < 900; i++) begin
            if (i == 780) quiet_tail = 1;
            random_request();
        end
        s_tvalid <= 0;
        sending_done = 1;
    end

    // result side
    initial begin
        m_tready = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                m_tready <= 0;
                repeat ($urandom_range(1, 7)) @(negedge aclk);
            end
            m_tready <= 1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_reply(m_tdata[8:0]);
    end

    initial begin
        wait (sending_done);
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (NSLOT + 10) @(posedge aclk);
        if (board.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
+incdir+rtl
rtl/lbc_pkg.sv
rtl/lbc_ctrl.sv
rtl/lbc_datapath.sv
rtl/lru_block_buffer_cache_top.sv
rtl/lbc_checker.sv
bench/lru_block_buffer_cache_top_test.sv
